// ===== rtl/uvts_pkg.sv =====
package uvts_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CfgOperationMinutes = 2'd0,
    CfgStandbyHours     = 2'd1,
    CfgTicksPerMinute   = 2'd2,
    CfgMoveTimeoutTicks = 2'd3
  } cfg_index_t;

  localparam int CfgDataWidth = 10;

  localparam logic [7:0] OperationMinutesReset = 8'd120;
  localparam logic [3:0] StandbyHoursReset     = 4'd10;
  localparam logic [9:0] TicksPerMinuteReset   = 10'd600;
  localparam logic [9:0] MoveTimeoutReset      = 10'd600;

  localparam logic [5:0] MinutesPerHour = 6'd60;

  // Tray positions reported by the appliance.
  localparam logic [1:0] PosIceMaking = 2'd1;
  localparam logic [1:0] PosIceThrow  = 2'd2;

  typedef enum logic [3:0] {
    StepStandby   = 4'd0,
    StepDown1     = 4'd1,
    StepDownChk1  = 4'd2,
    StepUvDown    = 4'd3,
    StepWait2     = 4'd4,
    StepUp        = 4'd5,
    StepUpChk     = 4'd6,
    StepUvUp      = 4'd7,
    StepDown2     = 4'd8,
    StepDownChk2  = 4'd9,
    StepFinish    = 4'd10
  } step_t;

  typedef struct packed {
    logic       ice_on;
    logic       ice_disabled;
    logic       other_busy;
    logic       cover_present;
    logic       system_ok;
    logic       down_motor_busy;
    logic       up_motor_busy;
    logic [1:0] tray_position;
    logic       tank_open;
    logic       extracting;
  } in_t;

  typedef struct packed {
    logic       uv_on;
    logic       tray_down_cmd;
    logic       tray_up_cmd;
    logic [3:0] step;
  } out_t;

  typedef struct packed {
    logic [7:0] operation_minutes;
    logic [3:0] standby_hours;
    logic [9:0] ticks_per_minute;
    logic [9:0] move_timeout_ticks;
  } cfg_t;

  typedef struct packed {
    step_t      seq_step;
    logic [9:0] move_timer;
    logic [9:0] run_ticks;
    logic [7:0] run_minutes;
    logic [9:0] wait_ticks;
    logic [5:0] wait_minutes;
    logic [3:0] wait_hours;
    logic       uv_armed;
  } state_t;

endpackage

// ===== rtl/uv_tray_sterilize_sequencer_core.sv =====
// UV tray sterilisation sequencer. Each input word is one 100 ms tick of appliance
// status; each accepted tick gives exactly one result word in the next cycle, carrying
// the UV lamp flag, one-tick tray commands and the step after the update. A new tick
// is taken in every cycle as long as the result register is free or being emptied in the
// same cycle; the only limit is that single output register. Configuration is written
// through cfg_we/cfg_index/cfg_data by the user while idle; the core does not enforce this.
module uv_tray_sterilize_sequencer_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  uvts_pkg::in_t                        in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output uvts_pkg::out_t                       out_data,
  input  logic                                 cfg_we,
  input  uvts_pkg::cfg_index_t                 cfg_index,
  input  logic [uvts_pkg::CfgDataWidth-1:0]    cfg_data
);

  uvts_pkg::cfg_t   cfg;
  uvts_pkg::state_t st;
  uvts_pkg::state_t st_next;
  uvts_pkg::out_t   dout;
  logic             accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.operation_minutes  <= uvts_pkg::OperationMinutesReset;
      cfg.standby_hours      <= uvts_pkg::StandbyHoursReset;
      cfg.ticks_per_minute   <= uvts_pkg::TicksPerMinuteReset;
      cfg.move_timeout_ticks <= uvts_pkg::MoveTimeoutReset;
    end else if (cfg_we) begin
      case (cfg_index)
        uvts_pkg::CfgOperationMinutes: cfg.operation_minutes  <= cfg_data[7:0];
        uvts_pkg::CfgStandbyHours:     cfg.standby_hours      <= cfg_data[3:0];
        uvts_pkg::CfgTicksPerMinute:   cfg.ticks_per_minute   <= cfg_data[9:0];
        uvts_pkg::CfgMoveTimeoutTicks: cfg.move_timeout_ticks <= cfg_data[9:0];
        default: begin
          cfg.operation_minutes <= cfg.operation_minutes;
        end
      endcase
    end
  end

  uvts_step u_step (
    .cfg     (cfg),
    .st      (st),
    .din     (in_data),
    .st_next (st_next),
    .dout    (dout)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (accept) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= dout;
    end
  end

  a_accept_gives_word: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted tick produced no result word");

  a_one_tray_cmd: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.tray_down_cmd && out_data.tray_up_cmd))
    else $error("tray up and down commanded together");

  a_uv_in_run_step: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.uv_on) |->
      (out_data.step == uvts_pkg::StepUvDown || out_data.step == uvts_pkg::StepUvUp))
    else $error("UV lamp on outside a UV run step");

  a_step_in_range: assert property (@(posedge clk) disable iff (rst)
    st.seq_step <= uvts_pkg::StepFinish)
    else $error("sequence step beyond finish");

endmodule

// ===== rtl/uvts_step.sv =====
module uvts_step (
  input  uvts_pkg::cfg_t   cfg,
  input  uvts_pkg::state_t st,
  input  uvts_pkg::in_t    din,
  output uvts_pkg::state_t st_next,
  output uvts_pkg::out_t   dout
);

  logic abort;
  logic in_move_step;

  // Wait counter chain: ticks, minutes, saturating hours.
  logic [9:0] wt_inc, wt_new;
  logic       wt_roll;
  logic [5:0] wm_inc, wm_new;
  logic       wm_roll;
  logic [3:0] wh_new;
  logic       wait_done;

  // UV run counter chain.
  logic [9:0] rt_inc, rt_new;
  logic       rt_roll;
  logic [7:0] rm_new;
  logic       run_done;

  // Tray move timeout.
  logic [9:0] mt_inc;
  logic       move_done;

  logic uv_ok;

  assign abort = (din.ice_on && !din.ice_disabled) || din.other_busy || !din.cover_present;
  assign in_move_step = (st.seq_step == uvts_pkg::StepUp) || (st.seq_step == uvts_pkg::StepUpChk)
                     || (st.seq_step == uvts_pkg::StepUvUp) || (st.seq_step == uvts_pkg::StepDown2);

  assign wt_inc    = st.wait_ticks + 10'd1;
  assign wt_roll   = wt_inc >= cfg.ticks_per_minute;
  assign wt_new    = wt_roll ? 10'd0 : wt_inc;
  assign wm_inc    = wt_roll ? st.wait_minutes + 6'd1 : st.wait_minutes;
  assign wm_roll   = wm_inc >= uvts_pkg::MinutesPerHour;
  assign wm_new    = wm_roll ? 6'd0 : wm_inc;
  assign wh_new    = (wm_roll && st.wait_hours != 4'hF) ? st.wait_hours + 4'd1 : st.wait_hours;
  assign wait_done = wh_new >= cfg.standby_hours;

  assign rt_inc   = st.run_ticks + 10'd1;
  assign rt_roll  = rt_inc >= cfg.ticks_per_minute;
  assign rt_new   = rt_roll ? 10'd0 : rt_inc;
  assign rm_new   = (rt_roll && st.run_minutes != 8'hFF) ? st.run_minutes + 8'd1
                                                          : st.run_minutes;
  assign run_done = rm_new >= cfg.operation_minutes;

  assign mt_inc    = st.move_timer + 10'd1;
  assign move_done = mt_inc >= cfg.move_timeout_ticks;

  assign uv_ok = !din.tank_open && !din.extracting;

  // Next state.
  always_comb begin
    st_next = st;
    if (abort) begin
      st_next.run_ticks    = '0;
      st_next.run_minutes  = '0;
      st_next.wait_ticks   = '0;
      st_next.wait_minutes = '0;
      st_next.wait_hours   = '0;
      st_next.seq_step     = uvts_pkg::StepStandby;
      st_next.uv_armed     = 1'b0;
    end else begin
      case (st.seq_step)
        uvts_pkg::StepStandby, uvts_pkg::StepWait2: begin
          if (wait_done) begin
            st_next.run_ticks    = '0;
            st_next.run_minutes  = '0;
            st_next.wait_ticks   = '0;
            st_next.wait_minutes = '0;
            st_next.wait_hours   = '0;
            st_next.uv_armed     = 1'b1;
            if (st.seq_step == uvts_pkg::StepStandby) begin
              st_next.move_timer = '0;
              st_next.seq_step   = uvts_pkg::StepDown1;
            end else begin
              st_next.seq_step   = uvts_pkg::StepUp;
            end
          end else begin
            st_next.wait_ticks   = wt_new;
            st_next.wait_minutes = wm_new;
            st_next.wait_hours   = wh_new;
          end
        end
        uvts_pkg::StepDown1, uvts_pkg::StepUp, uvts_pkg::StepDown2: begin
          if (din.system_ok && !((st.seq_step == uvts_pkg::StepUp) ? din.up_motor_busy
                                                                   : din.down_motor_busy)) begin
            st_next.move_timer = '0;
            st_next.seq_step   = uvts_pkg::step_t'(st.seq_step + 4'd1);
          end else if (din.system_ok && !move_done) begin
            st_next.move_timer = mt_inc;
          end else begin
            // Fault or timeout: skip the check step and go on to the next UV run, or to finish after the last move.
            st_next.move_timer = '0;
            st_next.seq_step   = uvts_pkg::step_t'(st.seq_step + 4'd2);
          end
        end
        uvts_pkg::StepDownChk1, uvts_pkg::StepUpChk, uvts_pkg::StepDownChk2: begin
          if (din.tray_position == ((st.seq_step == uvts_pkg::StepUpChk) ?
                                    uvts_pkg::PosIceMaking : uvts_pkg::PosIceThrow)
              || move_done) begin
            st_next.move_timer = '0;
            st_next.seq_step   = uvts_pkg::step_t'(st.seq_step + 4'd1);
          end else begin
            st_next.move_timer = mt_inc;
          end
        end
        uvts_pkg::StepUvDown, uvts_pkg::StepUvUp: begin
          if (st.uv_armed) begin
            if (uv_ok) begin
              if (run_done) begin
                st_next.uv_armed     = 1'b0;
                st_next.run_ticks    = '0;
                st_next.run_minutes  = '0;
                st_next.wait_ticks   = '0;
                st_next.wait_minutes = '0;
                st_next.wait_hours   = '0;
              end else begin
                st_next.run_ticks   = rt_new;
                st_next.run_minutes = rm_new;
              end
            end
          end else begin
            st_next.move_timer = '0;
            st_next.seq_step   = uvts_pkg::step_t'(st.seq_step + 4'd1);
          end
        end
        uvts_pkg::StepFinish: begin
          st_next.move_timer   = '0;
          st_next.seq_step     = uvts_pkg::StepStandby;
          st_next.run_ticks    = '0;
          st_next.run_minutes  = '0;
          st_next.wait_ticks   = '0;
          st_next.wait_minutes = '0;
          st_next.wait_hours   = '0;
        end
        default: begin
          st_next.move_timer = '0;
          st_next.seq_step   = uvts_pkg::StepStandby;
        end
      endcase
    end
  end

  // Outputs of this tick.
  always_comb begin
    dout.uv_on         = 1'b0;
    dout.tray_down_cmd = 1'b0;
    dout.tray_up_cmd   = 1'b0;
    dout.step          = st_next.seq_step;
    if (abort) begin
      // Leaving with the tray up: send it back down if the motor is free.
      dout.tray_down_cmd = in_move_step && din.system_ok && !din.down_motor_busy
                        && din.tray_position != uvts_pkg::PosIceThrow;
    end else begin
      case (st.seq_step)
        uvts_pkg::StepDown1, uvts_pkg::StepDown2:
          dout.tray_down_cmd = din.system_ok && !din.down_motor_busy;
        uvts_pkg::StepUp:
          dout.tray_up_cmd = din.system_ok && !din.up_motor_busy;
        uvts_pkg::StepUvDown, uvts_pkg::StepUvUp:
          dout.uv_on = st.uv_armed && uv_ok;
        default: begin
          dout.uv_on = 1'b0;
        end
      endcase
    end
  end

endmodule
